// File: rtl/hdus_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hdus_pkg;

    // One input beat: a single character of the date string.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_beat;

    // One output beat: the converted time and its validity flag.
    typedef struct packed {
        logic [31:0] unix_seconds;
        logic        date_ok;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic num_digit;
        logic num_sign;
        logic num_clear;
        logic store_day;
        logic store_year;
        logic store_hour;
        logic store_minute;
        logic month_push;
        logic clear_all;
        logic calc1;
        logic parse_good;
        logic calc2;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic       digit_seen;
        logic       sign_seen;
        logic       num_bad;
        logic [1:0] month_count;
    } t_dp_status;

    // Result of the month name lookup.
    typedef struct packed {
        logic       valid;
        logic [3:0] idx;
    } t_month;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_PLUS   = 8'd43;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // Number and range limits.
    localparam int         NUM_W     = 17;
    localparam logic [16:0] NUM_MAX  = 17'd131071;
    localparam logic [16:0] YEAR_MIN = 17'd1970;
    localparam logic [16:0] YEAR_MAX = 17'd2100;
    localparam logic [16:0] DAY_MAX  = 17'd31;
    localparam logic [16:0] HOUR_MAX = 17'd23;
    localparam logic [16:0] MIN_MAX  = 17'd59;
    localparam logic [16:0] SEC_MAX  = 17'd60;

    // Calendar arithmetic constants.
    localparam logic [11:0] ERA_START_4   = 12'd1600;
    localparam logic [11:0] ERA_START_5   = 12'd2000;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
    localparam logic [17:0] DAYS_OFS_ERA4 = 18'(4 * 146097 - 719468);
    localparam logic [17:0] DAYS_OFS_ERA5 = 18'(5 * 146097 - 719468);
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

    localparam logic [23:0] MONTH_NAMES [12] = '{
        "jan", "feb", "mar", "apr", "may", "jun",
        "jul", "aug", "sep", "oct", "nov", "dec"
    };

    // Folds A-Z to lower case and leaves every other code alone.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    // Matches three characters against the month names.
    function automatic t_month month_lookup(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2);
        t_month     m;
        logic [23:0] key;
        m   = '0;
        key = {fold_case(c0), fold_case(c1), fold_case(c2)};
        for (int i = 0; i < 12; i++) begin
            if (key == MONTH_NAMES[i]) begin
                m.valid = 1'b1;
                m.idx   = 4'(i);
            end
        end
        return m;
    endfunction

    // Day of a March-based year on which each month starts (Jan and Feb at the end).
    function automatic logic [8:0] month_doy_base(input logic [3:0] idx);
        logic [8:0] r;
        case (idx)
            4'd0:    r = 9'd306;
            4'd1:    r = 9'd337;
            4'd2:    r = 9'd0;
            4'd3:    r = 9'd31;
            4'd4:    r = 9'd61;
            4'd5:    r = 9'd92;
            4'd6:    r = 9'd122;
            4'd7:    r = 9'd153;
            4'd8:    r = 9'd184;
            4'd9:    r = 9'd214;
            4'd10:   r = 9'd245;
            4'd11:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hdus_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module hdus_dpath (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [7:0]             i_char,
    input  wire hdus_pkg::t_dp_cmd      i_cmd,
    output hdus_pkg::t_dp_status        o_status,
    output hdus_pkg::t_out_beat         o_out_data
);

    import hdus_pkg::*;

    // Number being read and its flags.
    logic [16:0] r_accum;
    logic        r_neg;
    logic        r_digit_seen;
    logic        r_sign_seen;

    // Month name characters.
    logic [7:0]  r_mon_chr [3];
    logic [1:0]  r_mon_cnt;

    // Stored date and time fields.
    logic [16:0] r_day;
    logic [16:0] r_year;
    logic [16:0] r_hour;
    logic [16:0] r_minute;

    // Calculation pipeline.
    logic [8:0]  r_yoe;
    logic        r_era5;
    logic [8:0]  r_doy;
    logic [16:0] r_tod;
    logic        r_ok;
    logic [15:0] r_days;
    t_out_beat   r_out;

    logic [20:0] accum_x10;
    logic [16:0] accum_next;
    t_month      mon;
    logic        mon_ok;
    logic        early_month;
    logic [11:0] yr_adj;
    logic        era5;
    logic [11:0] yoe_full;
    logic [8:0]  doy;
    logic [16:0] tod;
    logic        fields_ok;
    logic [1:0]  yoe_c100;
    logic [17:0] doe;
    logic [17:0] days_sum;
    logic [31:0] secs;

    // Decimal accumulate with saturation.
    always_comb begin
        accum_x10  = 21'({4'd0, r_accum}) * 21'd10 + 21'({17'd0, i_char[3:0]});
        accum_next = (accum_x10 > 21'(NUM_MAX)) ? NUM_MAX : accum_x10[16:0];
    end

    // Parse state: numbers, month letters and fields.
    // A sign that ends one number and opens the next wins over the clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            r_accum      <= '0;
            r_neg        <= 1'b0;
            r_digit_seen <= 1'b0;
            r_sign_seen  <= 1'b0;
            r_mon_chr[0] <= '0;
            r_mon_chr[1] <= '0;
            r_mon_chr[2] <= '0;
            r_mon_cnt    <= '0;
            r_day        <= '0;
            r_year       <= '0;
            r_hour       <= '0;
            r_minute     <= '0;
        end else begin
            if (i_cmd.num_clear) begin
                r_accum      <= '0;
                r_digit_seen <= 1'b0;
            end else if (i_cmd.num_digit) begin
                r_accum      <= accum_next;
                r_digit_seen <= 1'b1;
            end
            if (i_cmd.num_sign) begin
                r_sign_seen <= 1'b1;
                r_neg       <= (i_char == CH_MINUS);
            end else if (i_cmd.num_clear) begin
                r_sign_seen <= 1'b0;
                r_neg       <= 1'b0;
            end
            if (i_cmd.month_push) begin
                r_mon_chr[r_mon_cnt] <= i_char;
                r_mon_cnt            <= r_mon_cnt + 2'd1;
            end
            if (i_cmd.store_day) begin
                r_day <= r_accum;
            end
            if (i_cmd.store_year) begin
                r_year <= r_accum;
            end
            if (i_cmd.store_hour) begin
                r_hour <= r_accum;
            end
            if (i_cmd.store_minute) begin
                r_minute <= r_accum;
            end
        end
    end

    // First calculation step: month, era split, day of year, time of day, range checks.
    always_comb begin
        mon         = month_lookup(r_mon_chr[0], r_mon_chr[1], r_mon_chr[2]);
        mon_ok      = mon.valid && (r_mon_cnt == 2'd3);
        early_month = (mon.idx <= 4'd1);
        yr_adj      = r_year[11:0] - {11'd0, early_month};
        era5        = (yr_adj >= ERA_START_5);
        yoe_full    = yr_adj - (era5 ? ERA_START_5 : ERA_START_4);
        doy         = month_doy_base(mon.idx) + {4'd0, r_day[4:0]} - 9'd1;
        tod         = 17'({12'd0, r_hour[4:0]}) * SECS_PER_HOUR
                    + 17'({11'd0, r_minute[5:0]}) * SECS_PER_MIN
                    + 17'({11'd0, r_accum[5:0]});
        fields_ok   = mon_ok
                    && (r_year >= YEAR_MIN) && (r_year <= YEAR_MAX)
                    && (r_day != '0) && (r_day <= DAY_MAX)
                    && (r_hour <= HOUR_MAX) && (r_minute <= MIN_MAX)
                    && (r_accum <= SEC_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc1) begin
            r_yoe  <= yoe_full[8:0];
            r_era5 <= era5;
            r_doy  <= doy;
            r_tod  <= tod;
            r_ok   <= i_cmd.parse_good && fields_ok;
        end
    end

    // Second calculation step: day of era, then days since the epoch.
    always_comb begin
        if (r_yoe >= 9'd300) begin
            yoe_c100 = 2'd3;
        end else if (r_yoe >= 9'd200) begin
            yoe_c100 = 2'd2;
        end else if (r_yoe >= 9'd100) begin
            yoe_c100 = 2'd1;
        end else begin
            yoe_c100 = 2'd0;
        end
        doe      = 18'({9'd0, r_yoe}) * DAYS_PER_YEAR + 18'({11'd0, r_yoe[8:2]})
                 - 18'({16'd0, yoe_c100}) + 18'({9'd0, r_doy});
        days_sum = doe + (r_era5 ? DAYS_OFS_ERA5 : DAYS_OFS_ERA4);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc2) begin
            r_days <= days_sum[15:0];
        end
    end

    // Last step: scale days to seconds and load the output beat.
    always_comb begin
        secs = 32'({16'd0, r_days}) * SECS_PER_DAY + 32'({15'd0, r_tod});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.unix_seconds <= r_ok ? secs : '0;
            r_out.date_ok      <= r_ok;
        end
    end

    always_comb begin
        o_status.digit_seen  = r_digit_seen;
        o_status.sign_seen   = r_sign_seen;
        o_status.num_bad     = r_neg && (r_accum != '0);
        o_status.month_count = r_mon_cnt;
        o_out_data           = r_out;
    end

endmodule

`default_nettype wire

// File: rtl/hdus_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hdus_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire hdus_pkg::t_in_beat     i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    input  wire hdus_pkg::t_dp_status   i_status,
    output hdus_pkg::t_dp_cmd           o_cmd
);

    import hdus_pkg::*;

    typedef enum logic [9:0] {
        PH_WEEKDAY = 10'b00_0000_0001,
        PH_DAY     = 10'b00_0000_0010,
        PH_MONTH   = 10'b00_0000_0100,
        PH_YEAR    = 10'b00_0000_1000,
        PH_HOUR    = 10'b00_0001_0000,
        PH_COLON1  = 10'b00_0010_0000,
        PH_MINUTE  = 10'b00_0100_0000,
        PH_COLON2  = 10'b00_1000_0000,
        PH_SECOND  = 10'b01_0000_0000,
        PH_DONE    = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CALC1 = 4'b0010,
        S_CALC2 = 4'b0100,
        S_CALC3 = 4'b1000
    } t_ctl_state;

    t_phase     r_phase, n_phase;
    logic       r_failed, n_failed;
    t_ctl_state r_state, n_state;
    logic       r_out_valid, n_out_valid;

    t_dp_cmd    cmd;
    logic [7:0] c;
    logic       accept;
    logic       is_end;
    logic       is_digit;
    logic       is_ws;
    logic       is_sign;
    logic       out_free;

    // Character classes.
    always_comb begin
        c        = i_in_data.char_code;
        accept   = i_in_valid && (r_state == S_IDLE);
        is_end   = (c == CH_NUL) || i_in_data.last_char;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_ws    = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
        is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
        out_free = !r_out_valid || !i_out_stall;
    end

    // Parse sequencing and end-of-string calculation steps.
    always_comb begin
        n_phase     = r_phase;
        n_failed    = r_failed;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        cmd         = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (c != CH_NUL && !r_failed) begin
                        case (r_phase)
                            PH_WEEKDAY: begin
                                if (c == CH_COMMA) begin
                                    n_phase = PH_DAY;
                                end else if (is_digit) begin
                                    n_phase       = PH_DAY;
                                    cmd.num_digit = 1'b1;
                                end
                            end
                            PH_DAY, PH_YEAR, PH_HOUR, PH_MINUTE, PH_SECOND: begin
                                if (is_digit) begin
                                    cmd.num_digit = 1'b1;
                                end else if (!i_status.digit_seen) begin
                                    // Leading space or one sign before the digits.
                                    if (!i_status.sign_seen && is_sign) begin
                                        cmd.num_sign = 1'b1;
                                    end else if (i_status.sign_seen || !is_ws) begin
                                        n_failed = 1'b1;
                                    end
                                end else begin
                                    // The number ends here and the character is
                                    // handed to the next field.
                                    if (i_status.num_bad) begin
                                        n_failed = 1'b1;
                                    end
                                    if (r_phase == PH_SECOND) begin
                                        n_phase = PH_DONE;
                                    end else begin
                                        cmd.num_clear = 1'b1;
                                    end
                                    if (r_phase == PH_DAY) begin
                                        cmd.store_day = 1'b1;
                                        n_phase       = PH_MONTH;
                                        if (!is_ws) begin
                                            cmd.month_push = 1'b1;
                                        end
                                    end else if (r_phase == PH_YEAR) begin
                                        cmd.store_year = 1'b1;
                                        n_phase        = PH_HOUR;
                                        if (is_sign) begin
                                            cmd.num_sign = 1'b1;
                                        end else if (!is_ws) begin
                                            n_failed = 1'b1;
                                        end
                                    end else if (r_phase == PH_HOUR) begin
                                        cmd.store_hour = 1'b1;
                                        n_phase        = PH_COLON1;
                                        if (c == CH_COLON) begin
                                            n_phase = PH_MINUTE;
                                        end else begin
                                            n_failed = 1'b1;
                                        end
                                    end else if (r_phase == PH_MINUTE) begin
                                        cmd.store_minute = 1'b1;
                                        n_phase          = PH_COLON2;
                                        if (c == CH_COLON) begin
                                            n_phase = PH_SECOND;
                                        end else begin
                                            n_failed = 1'b1;
                                        end
                                    end
                                end
                            end
                            PH_MONTH: begin
                                if (is_ws) begin
                                    if (i_status.month_count != 2'd0) begin
                                        n_phase = PH_YEAR;
                                    end
                                end else begin
                                    cmd.month_push = 1'b1;
                                    if (i_status.month_count == 2'd2) begin
                                        n_phase = PH_YEAR;
                                    end
                                end
                            end
                            PH_COLON1: begin
                                if (c == CH_COLON) begin
                                    n_phase = PH_MINUTE;
                                end else begin
                                    n_failed = 1'b1;
                                end
                            end
                            PH_COLON2: begin
                                if (c == CH_COLON) begin
                                    n_phase = PH_SECOND;
                                end else begin
                                    n_failed = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                    if (is_end) begin
                        n_state = S_CALC1;
                    end
                end
            end
            S_CALC1: begin
                // A second that ends with the string is complete as well.
                cmd.calc1      = 1'b1;
                cmd.parse_good = !r_failed && ((r_phase == PH_DONE)
                               || (r_phase == PH_SECOND && i_status.digit_seen
                                   && !i_status.num_bad));
                cmd.clear_all  = 1'b1;
                n_phase        = PH_WEEKDAY;
                n_failed       = 1'b0;
                n_state        = S_CALC2;
            end
            S_CALC2: begin
                cmd.calc2 = 1'b1;
                n_state   = S_CALC3;
            end
            S_CALC3: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WEEKDAY;
            r_failed    <= 1'b0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_failed    <= n_failed;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd       = cmd;
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = r_out_valid;
    end

    // The output register is only overwritten once its beat has gone.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output beat overwritten before it was taken");

    // The end of a string starts the calculation on the next cycle.
    a_end_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_end) |=> (r_state == S_CALC1))
        else $error("end of string did not start the calculation");

    // Parse state is back at its start after the first calculation step.
    a_parse_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC1) |=> (r_phase == PH_WEEKDAY && !r_failed))
        else $error("parse state not cleared for the next string");

    // A failed parse stays failed while characters come in.
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && r_state == S_IDLE) |=> r_failed)
        else $error("parse failure was lost");

endmodule

`default_nettype wire

// File: rtl/http_date_to_unix_seconds.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Beat
// in       input      i_in_valid / o_in_stall    one character and its last flag
// out      output     o_out_valid / i_out_stall  Unix seconds and date_ok, one per string
//
// Characters are taken at one per cycle while o_in_stall is low; each is parsed in the
// cycle it arrives. A NUL or a beat with last_char set ends the string; the input then
// stalls through the calculation steps (month lookup and range check, day count, scale
// to seconds) before the next string can start, longer if the previous result is still
// waiting. The result register lets the next string be read while a result waits.
// Reset is synchronous and active low; it returns the parser to the weekday skip.
module http_date_to_unix_seconds (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire hdus_pkg::t_in_beat     i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output hdus_pkg::t_out_beat         o_out_data
);

    import hdus_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencing of the parse and of the calculation steps.
    hdus_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Field storage and calendar arithmetic.
    hdus_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_in_data.char_code),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

// File: bench/unix_time_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the date converter. Every accepted character beat
// is run through a local parser that tracks the block's parse state, and each
// end of string queues the expected time beat. Every accepted time beat is
// compared field by field with the oldest queued one.
module unix_time_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  hdus_pkg::t_in_beat   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  hdus_pkg::t_out_beat  i_out_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    import hdus_pkg::*;

    typedef enum bit [3:0] {
        ST_WEEKDAY,
        ST_DAY,
        ST_MONTH,
        ST_YEAR,
        ST_HOUR,
        ST_COLON1,
        ST_MINUTE,
        ST_COLON2,
        ST_SECOND,
        ST_DONE
    } parse_step_t;

    // Local copy of the parser state.
    parse_step_t step;
    bit [31:0]   number_value;
    bit          number_minus;
    bit          number_has_digit;
    bit          number_has_sign;
    bit [23:0]   month_chars;
    bit [1:0]    month_char_count;
    bit [31:0]   day_value;
    bit [31:0]   year_value;
    bit [31:0]   hour_value;
    bit [31:0]   minute_value;
    bit          parse_broken;

    t_out_beat   expected_times[$];
    t_out_beat   oldest_time;
    int          mismatch_total;

    function automatic bit is_blank(input bit [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_decimal(input bit [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_parser();
        step             = ST_WEEKDAY;
        number_value     = 0;
        number_minus     = 1'b0;
        number_has_digit = 1'b0;
        number_has_sign  = 1'b0;
        month_chars      = '0;
        month_char_count = '0;
        day_value        = 0;
        year_value       = 0;
        hour_value       = 0;
        minute_value     = 0;
        parse_broken     = 1'b0;
    endfunction

    // Month number 1..12 from the three collected characters, 0 when none matches.
    function automatic int month_number();
        if (month_char_count != 2'd3) begin
            return 0;
        end
        case (month_chars)
            "jan": return 1;
            "feb": return 2;
            "mar": return 3;
            "apr": return 4;
            "may": return 5;
            "jun": return 6;
            "jul": return 7;
            "aug": return 8;
            "sep": return 9;
            "oct": return 10;
            "nov": return 11;
            "dec": return 12;
            default: return 0;
        endcase
    endfunction

    // Days from 1970-01-01 to the given civil date, using a March-based year.
    function automatic bit [31:0] days_since_epoch(input bit [31:0] y, input bit [31:0] m,
                                                   input bit [31:0] d);
        bit [31:0] yy;
        bit [31:0] era;
        bit [31:0] yoe;
        bit [31:0] mp;
        bit [31:0] doy;
        bit [31:0] doe;
        yy  = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    // Feeds one character to the number being read; returns 1 when the
    // character ends the number and still has to be handled.
    function automatic bit number_absorb(input bit [7:0] c);
        if (is_decimal(c)) begin
            number_value = number_value * 10 + (c - CH_ZERO);
            if (number_value > NUM_MAX) begin
                number_value = NUM_MAX;
            end
            number_has_digit = 1'b1;
            return 1'b0;
        end
        if (!number_has_digit) begin
            if (!number_has_sign && is_blank(c)) begin
                return 1'b0;
            end
            if (!number_has_sign && (c == CH_PLUS || c == CH_MINUS)) begin
                number_has_sign = 1'b1;
                number_minus    = (c == CH_MINUS);
                return 1'b0;
            end
            parse_broken = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Hands out the finished number; only minus zero may carry a minus sign.
    function automatic bit [31:0] number_collect();
        bit [31:0] v;
        v = number_value;
        if (number_minus && v != 0) begin
            parse_broken = 1'b1;
        end
        number_value     = 0;
        number_minus     = 1'b0;
        number_has_digit = 1'b0;
        number_has_sign  = 1'b0;
        return v;
    endfunction

    function automatic void month_close();
        if (month_number() == 0) begin
            parse_broken = 1'b1;
        end
        step = ST_YEAR;
    endfunction

    // Advances the parser by one character; returns 1 when it was used up.
    function automatic bit parse_char(input bit [7:0] c);
        bit [31:0] v;
        bit [7:0]  lower;
        case (step)
            ST_WEEKDAY: begin
                if (c == CH_COMMA) begin
                    step = ST_DAY;
                    return 1'b1;
                end
                if (is_decimal(c)) begin
                    step = ST_DAY;
                    return 1'b0;
                end
                return 1'b1;
            end
            ST_DAY, ST_YEAR, ST_HOUR, ST_MINUTE: begin
                if (!number_absorb(c)) begin
                    return 1'b1;
                end
                v = number_collect();
                case (step)
                    ST_DAY: begin
                        day_value = v;
                        step      = ST_MONTH;
                    end
                    ST_YEAR: begin
                        year_value = v;
                        step       = ST_HOUR;
                    end
                    ST_HOUR: begin
                        hour_value = v;
                        step       = ST_COLON1;
                    end
                    default: begin
                        minute_value = v;
                        step         = ST_COLON2;
                    end
                endcase
                return 1'b0;
            end
            ST_MONTH: begin
                if (is_blank(c)) begin
                    if (month_char_count == 0) begin
                        return 1'b1;
                    end
                    month_close();
                    return 1'b0;
                end
                lower = c;
                if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    lower = c + CASE_OFFSET;
                end
                month_chars      = {month_chars[15:0], lower};
                month_char_count = month_char_count + 1'b1;
                if (month_char_count == 2'd3) begin
                    month_close();
                end
                return 1'b1;
            end
            ST_COLON1, ST_COLON2: begin
                if (c == CH_COLON) begin
                    step = (step == ST_COLON1) ? ST_MINUTE : ST_SECOND;
                end else begin
                    parse_broken = 1'b1;
                end
                return 1'b1;
            end
            ST_SECOND: begin
                if (number_absorb(c)) begin
                    if (number_minus && number_value != 0) begin
                        parse_broken = 1'b1;
                    end
                    step = ST_DONE;
                end
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    // End of string: range checks, conversion, and the queued time beat.
    function automatic void close_string();
        t_out_beat beat;
        int        m;
        bit        good;
        if (!parse_broken && step == ST_SECOND && number_has_digit) begin
            if (number_minus && number_value != 0) begin
                parse_broken = 1'b1;
            end
            step = ST_DONE;
        end
        m    = month_number();
        good = !parse_broken && step == ST_DONE && m != 0 &&
               year_value >= YEAR_MIN && year_value <= YEAR_MAX &&
               day_value >= 1 && day_value <= DAY_MAX &&
               hour_value <= HOUR_MAX && minute_value <= MIN_MAX &&
               number_value <= SEC_MAX;
        beat = '0;
        if (good) begin
            beat.unix_seconds = days_since_epoch(year_value, m, day_value) * 32'd86400 +
                                hour_value * 32'd3600 + minute_value * 32'd60 + number_value;
        end
        beat.date_ok = good;
        expected_times.push_back(beat);
        clear_parser();
    endfunction

    // A NUL ends the string without being parsed; a flagged character is
    // parsed first and then ends it.
    function automatic void take_char(input bit [7:0] c, input bit last);
        bit used;
        if (c != CH_NUL) begin
            used = 1'b0;
            while (!parse_broken && !used) begin
                used = parse_char(c);
            end
        end
        if (c == CH_NUL || last) begin
            close_string();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: unix_time_checker: %s", $time, what);
        mismatch_total++;
    endtask

    // Results are checked before the character of the same edge is parsed,
    // since no result can leave in the cycle its string ends.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            expected_times.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    report_mismatch($sformatf("time beat %0d/%0b with no string ended",
                                              i_out_data.unix_seconds, i_out_data.date_ok));
                end else begin
                    oldest_time = expected_times.pop_front();
                    if (i_out_data.unix_seconds !== oldest_time.unix_seconds) begin
                        report_mismatch($sformatf("unix_seconds %0d, predicted %0d",
                                                  i_out_data.unix_seconds,
                                                  oldest_time.unix_seconds));
                    end
                    if (i_out_data.date_ok !== oldest_time.date_ok) begin
                        report_mismatch($sformatf("date_ok %b, predicted %b",
                                                  i_out_data.date_ok, oldest_time.date_ok));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                take_char(i_in_data.char_code, i_in_data.last_char);
            end
        end
        o_pending    <= expected_times.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// File: bench/tb_http_date_to_unix_seconds.sv
`timescale 1ns / 1ps

// Drives date strings into the converter one character beat at a time and
// stalls the result side at random; the checker beside the block does the
// prediction and comparison.
module tb_http_date_to_unix_seconds;

    import hdus_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 20;

    // How a string is ended.
    typedef enum bit [1:0] {
        TERM_LAST,
        TERM_NUL,
        TERM_NUL_LAST
    } term_t;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      char_valid = 1'b0;
    logic      char_stall;
    t_in_beat  char_beat  = '0;
    logic      time_valid;
    logic      time_stall = 1'b0;
    t_out_beat time_beat;

    int        pending_times;
    int        fail_count;
    bit        tx_steady = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    http_date_to_unix_seconds dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (char_valid),
        .o_in_stall  (char_stall),
        .i_in_data   (char_beat),
        .o_out_valid (time_valid),
        .i_out_stall (time_stall),
        .o_out_data  (time_beat)
    );

    unix_time_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (char_valid),
        .i_in_stall   (char_stall),
        .i_in_data    (char_beat),
        .i_out_valid  (time_valid),
        .i_out_stall  (time_stall),
        .i_out_data   (time_beat),
        .o_pending    (pending_times),
        .o_fail_count (fail_count)
    );

    // Offers one character beat, with a random idle gap first, and returns
    // at the edge where it is taken.
    task automatic send_char(input bit [7:0] c, input bit last);
        while (!tx_steady && $urandom_range(99) < 10) begin
            char_valid <= 1'b0;
            @(posedge i_clk);
        end
        char_valid          <= 1'b1;
        char_beat.char_code <= c;
        char_beat.last_char <= last;
        @(posedge i_clk);
        while (char_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_string(input string s, input term_t term);
        int n;
        n = s.len();
        for (int i = 0; i < n; i++) begin
            send_char(s[i], term == TERM_LAST && i == n - 1);
        end
        if (term != TERM_LAST || n == 0) begin
            send_char(CH_NUL, term != TERM_NUL);
        end
    endtask

    // A run of min_n blanks, now and then up to two more; mostly spaces, sometimes tabs and line breaks.
    function automatic string blank_run(input int min_n);
        string s;
        int    n;
        s = "";
        n = min_n + (($urandom_range(9) == 0) ? $urandom_range(2) : 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                s = $sformatf("%s%c", s, $urandom_range(CH_TAB, CH_CR));
            end else begin
                s = {s, " "};
            end
        end
        return s;
    endfunction

    // Decimal text with the odd leading zeros or sign.
    function automatic string num_text(input int v);
        int r;
        r = $urandom_range(39);
        if (r < 24) return $sformatf("%0d", v);
        if (r < 32) return $sformatf("%04d", v);
        if (r < 38) return $sformatf("+%0d", v);
        if (r == 38) return $sformatf("-%0d", v);
        return $sformatf("%s%0d", blank_run(1), v);
    endfunction

    // A well formed date with random content; now and then one field strays out of range.
    function automatic string random_date();
        string wd;
        string mon;
        string tail;
        int    d, y, hh, mm, ss, k;
        d  = $urandom_range(1, 31);
        y  = $urandom_range(1970, 2100);
        hh = $urandom_range(23);
        mm = $urandom_range(59);
        ss = $urandom_range(60);
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(5))
                0: d  = ($urandom_range(1) == 0) ? 0 : $urandom_range(32, 99);
                1: y  = $urandom_range(0, 1969);
                2: y  = ($urandom_range(1) == 0) ? $urandom_range(2101, 9999) : 9999999;
                3: hh = $urandom_range(24, 99);
                4: mm = $urandom_range(60, 99);
                default: ss = $urandom_range(61, 99);
            endcase
        end
        k  = $urandom_range(6);
        wd = "SunMonTueWedThuFriSat";
        wd = wd.substr(3 * k, 3 * k + 2);
        case ($urandom_range(3))
            0: wd = "";
            1: wd = {wd, ", "};
            2: wd = {wd, ","};
            default: wd = {wd, " "};
        endcase
        k   = $urandom_range(11);
        mon = "JanFebMarAprMayJunJulAugSepOctNovDec";
        mon = mon.substr(3 * k, 3 * k + 2);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(3) == 0) begin
                mon.putc(i, mon[i] ^ CASE_OFFSET);
            end
        end
        case ($urandom_range(3))
            0: tail = "";
            1: tail = " GMT";
            default: tail = $sformatf("%0s%c", blank_run(0), $urandom_range(1, 255));
        endcase
        return {wd, num_text(d), blank_run(($urandom_range(7) == 0) ? 0 : 1), mon,
                blank_run(($urandom_range(7) == 0) ? 0 : 1), num_text(y), blank_run(1),
                num_text(hh), ":", num_text(mm), ":", num_text(ss), tail};
    endfunction

    // Random bytes, half of them drawn from the characters the parser cares about.
    function automatic string noise_text();
        string pool;
        string s;
        int    n;
        pool = "0123456789:+- ,JanDec\t";
        s    = "";
        n    = $urandom_range(12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1) == 0) begin
                s = $sformatf("%s%c", s, pool[$urandom_range(pool.len() - 1)]);
            end else begin
                s = $sformatf("%s%c", s, $urandom_range(1, 255));
            end
        end
        return s;
    endfunction

    // Result side: random stalls, one long hold-off that backs up the block,
    // and a stretch with no stalls at all.
    initial begin : result_stall_driver
        int cycle_n;
        cycle_n = 0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            @(posedge i_clk);
            cycle_n++;
            if (cycle_n >= 300 && cycle_n < 500) begin
                time_stall <= 1'b1;
            end else if (cycle_n >= 600 && cycle_n < 900) begin
                time_stall <= 1'b0;
            end else begin
                time_stall <= ($urandom_range(99) < 10);
            end
        end
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_http_date_to_unix_seconds: errors");
        $finish;
    end

    initial begin : stimulus
        string s;
        int    rand_chars;
        int    rand_strings;
        int    pick;
        int    k;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: limits, signs, month spelling, early ends, blanks.
        send_string("Sun, 20 Sep 2026 20:30:00 GMT", TERM_LAST);
        send_string("Thu, 01 Jan 1970 00:00:00 GMT", TERM_NUL);
        send_string("Fri, 31 Dec 2100 23:59:60 GMT", TERM_NUL_LAST);
        send_string("31 dEC 2099 23:59:59", TERM_LAST);
        send_string(",1Jan2000 12:00:00", TERM_LAST);
        send_string("Sat, 31 Feb 2024 06:07:08", TERM_LAST);
        send_string("Tue, 29 Feb 2000 01:02:03", TERM_LAST);
        send_string("Mon, 1 Mar 2100 00:00:00", TERM_LAST);
        send_string("Wed, 9999999 Jan 2000 00:00:00", TERM_LAST);
        send_string("-0 Jan +2000 -0:+0:-0", TERM_LAST);
        send_string("Wed, -1 Jan 2000 00:00:00", TERM_LAST);
        send_string("Wed, 1 Jan 2000 00:00:-1", TERM_LAST);
        send_string("Wed, + 1 Jan 2000 00:00:00", TERM_LAST);
        send_string("Wed, 1 Jan 2000 --3:00:00", TERM_LAST);
        send_string("Wed, 1 Ja 2000 00:00:00", TERM_LAST);
        send_string("Wed, 1 Janu 2000 00:00:00", TERM_LAST);
        send_string("Wed, 1 J4n 2000 00:00:00", TERM_LAST);
        send_string("Wed, 0 Jan 1969 24:60:61", TERM_LAST);
        send_string("Wed, 32 Jan 2101 00:00:00", TERM_LAST);
        send_string("Wed, 1 Jan 2000 00 :00:00", TERM_LAST);
        send_string("Wed, 1 Jan 2000 12:30", TERM_NUL);
        send_string("", TERM_NUL);
        send_string("", TERM_NUL_LAST);
        send_string("\011\012 1\013Jan\0152000\01400:00:07 ", TERM_LAST);
        send_string("\377\200\001, 5 Aug 2038 03:14:07xyz", TERM_LAST);

        // Random strings: mostly well formed, the rest damaged or plain noise.
        // The first few go out with no idle gaps at all.
        rand_chars   = 0;
        rand_strings = 0;
        while (rand_chars < 120) begin
            tx_steady = (rand_strings < 4);
            pick      = $urandom_range(99);
            if (pick < 70) begin
                s = random_date();
            end else if (pick < 85) begin
                s = random_date();
                if ($urandom_range(1) == 0) begin
                    k = $urandom_range(s.len() - 1);
                    s.putc(k, $urandom_range(1, 255));
                end else begin
                    k = $urandom_range(1, s.len() - 1);
                    s = s.substr(0, k - 1);
                end
            end else begin
                s = noise_text();
            end
            send_string(s, term_t'($urandom_range(2)));
            rand_chars += s.len() + 1;
            rand_strings++;
        end
        tx_steady = 1'b0;
        char_valid <= 1'b0;

        // Drain: every predicted time beat must come out, and nothing after.
        @(posedge i_clk);
        while (pending_times != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_times == 0) begin
            $display("tb_http_date_to_unix_seconds: clean");
        end else begin
            $display("tb_http_date_to_unix_seconds: errors");
        end
        $finish;
    end

endmodule
